>>> design/lwn_pkg.sv
`default_nettype none

package lwn_pkg;

    localparam int SCAN_POINTS_DEF = 1024;
    localparam int RANGE_W         = 16;
    localparam int WIN_W           = 10;

    typedef struct packed {
        logic [RANGE_W-1:0] min_valid_range;
        logic [WIN_W-1:0]   win_lo;
        logic [WIN_W-1:0]   win_hi;
    } lwn_scan_cfg_t;

    typedef struct packed {
        logic               scan_ready;
        logic               best_found;
        logic               front_found;
        logic [RANGE_W-1:0] front_min;
    } lwn_scan_sum_t;

endpackage

`default_nettype wire

>>> design/lwn_scan.sv
`default_nettype none

module lwn_scan import lwn_pkg::*; #(
    parameter int SCAN_POINTS = SCAN_POINTS_DEF,
    parameter int IDX_W       = $clog2(SCAN_POINTS)
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               sample_en,
    input  wire logic [RANGE_W-1:0] range_mm,
    input  wire logic               range_finite,
    input  wire logic               scan_end,
    input  wire lwn_scan_cfg_t      cfg,
    output lwn_scan_sum_t           held,
    output logic [IDX_W-1:0]        held_best_index
);

    localparam int CNT_W = $clog2(SCAN_POINTS + 1);

    logic [CNT_W-1:0]   sample_index_reg, sample_index_next;
    logic [RANGE_W-1:0] run_best_range_reg, run_best_range_next;
    logic [IDX_W-1:0]   run_best_index_reg, run_best_index_next;
    logic               run_best_found_reg, run_best_found_next;
    logic [RANGE_W-1:0] run_front_min_reg, run_front_min_next;
    logic               run_front_found_reg, run_front_found_next;
    lwn_scan_sum_t      held_reg, held_next;
    logic [IDX_W-1:0]   held_best_index_reg, held_best_index_next;

    logic               in_range;
    logic               valid;
    logic               in_window;
    logic [RANGE_W-1:0] cand_best_range, cand_front_min;
    logic [IDX_W-1:0]   cand_best_index;
    logic               cand_best_found, cand_front_found;
    logic [CNT_W-1:0]   cand_index;

    always_comb begin
        in_range  = sample_index_reg < CNT_W'(SCAN_POINTS);
        valid     = range_finite && (range_mm > cfg.min_valid_range);
        in_window = (32'(sample_index_reg) >= 32'(cfg.win_lo)) &&
                    (32'(sample_index_reg) <= 32'(cfg.win_hi));

        cand_best_range  = run_best_range_reg;
        cand_best_index  = run_best_index_reg;
        cand_best_found  = run_best_found_reg;
        cand_front_min   = run_front_min_reg;
        cand_front_found = run_front_found_reg;
        cand_index       = sample_index_reg;

        if (in_range) begin
            if (valid && range_mm > run_best_range_reg) begin
                cand_best_range = range_mm;
                cand_best_index = sample_index_reg[IDX_W-1:0];
                cand_best_found = 1'b1;
            end
            if (valid && in_window && (!run_front_found_reg || range_mm < run_front_min_reg)) begin
                cand_front_min   = range_mm;
                cand_front_found = 1'b1;
            end
            cand_index = sample_index_reg + CNT_W'(1);
        end

        sample_index_next    = sample_index_reg;
        run_best_range_next  = run_best_range_reg;
        run_best_index_next  = run_best_index_reg;
        run_best_found_next  = run_best_found_reg;
        run_front_min_next   = run_front_min_reg;
        run_front_found_next = run_front_found_reg;
        held_next            = held_reg;
        held_best_index_next = held_best_index_reg;

        if (sample_en) begin
            if (scan_end) begin
                held_next.scan_ready  = 1'b1;
                held_next.best_found  = cand_best_found;
                held_next.front_found = cand_front_found;
                held_next.front_min   = cand_front_min;
                held_best_index_next  = cand_best_index;
                sample_index_next     = '0;
                run_best_range_next   = '0;
                run_best_index_next   = '0;
                run_best_found_next   = 1'b0;
                run_front_min_next    = '1;
                run_front_found_next  = 1'b0;
            end else begin
                sample_index_next    = cand_index;
                run_best_range_next  = cand_best_range;
                run_best_index_next  = cand_best_index;
                run_best_found_next  = cand_best_found;
                run_front_min_next   = cand_front_min;
                run_front_found_next = cand_front_found;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg      <= '0;
            run_best_range_reg    <= '0;
            run_best_index_reg    <= '0;
            run_best_found_reg    <= 1'b0;
            run_front_min_reg     <= '1;
            run_front_found_reg   <= 1'b0;
            held_reg.scan_ready   <= 1'b0;
            held_reg.best_found   <= 1'b0;
            held_reg.front_found  <= 1'b0;
            held_reg.front_min    <= '1;
            held_best_index_reg   <= '0;
        end else begin
            sample_index_reg    <= sample_index_next;
            run_best_range_reg  <= run_best_range_next;
            run_best_index_reg  <= run_best_index_next;
            run_best_found_reg  <= run_best_found_next;
            run_front_min_reg   <= run_front_min_next;
            run_front_found_reg <= run_front_found_next;
            held_reg            <= held_next;
            held_best_index_reg <= held_best_index_next;
        end
    end

    assign held            = held_reg;
    assign held_best_index = held_best_index_reg;

endmodule

`default_nettype wire

>>> design/lidar_wander_navigator_core.sv
// a tick's result is registered in the result register once it leaves the input register
// throughput: one transaction per cycle while the result register is free, samples and
// ticks alike; all work for an item is done between the input and result registers
// reset: synchronous active-low aresetn clears control state and sets the
// configuration registers to their defaults (navigation disabled)
`default_nettype none

module lidar_wander_navigator_core import lwn_pkg::*; #(
    parameter int SCAN_POINTS = SCAN_POINTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // range_mm[15:0], range_finite[16], zero pad
    input  wire logic        s_tuser,   // kind: 0 sample, 1 tick
    input  wire logic        s_tlast,   // scan_end

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // linear_speed[15:0], angular_rate[32:16],
                                        // nav_state[34:33], waiting_for_scan[35], zero pad

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int IDX_W = $clog2(SCAN_POINTS);

    localparam logic [2:0] REG_ENABLE      = 3'd0;
    localparam logic [2:0] REG_ANGLE_MIN   = 3'd1;
    localparam logic [2:0] REG_ANGLE_STEP  = 3'd2;
    localparam logic [2:0] REG_FRONT_FIRST = 3'd3;
    localparam logic [2:0] REG_FRONT_LAST  = 3'd4;
    localparam logic [2:0] REG_STOP_DIST   = 3'd5;
    localparam logic [2:0] REG_MIN_VALID   = 3'd6;
    localparam logic [2:0] REG_PAUSE       = 3'd7;

    localparam logic [1:0] MODE_SEARCH = 2'd0;
    localparam logic [1:0] MODE_ALIGN  = 2'd1;
    localparam logic [1:0] MODE_MOVE   = 2'd2;
    localparam logic [1:0] MODE_STOP   = 2'd3;

    localparam logic [15:0] FWD_SPEED   = 16'd260;
    localparam logic [31:0] ALIGN_TOL   = 32'd6554;
    localparam logic [31:0] CLAMP_MAG   = 32'd49152;
    localparam logic [15:0] TURN_LIMIT  = 16'd39322;
    localparam logic [11:0] TURN_STEP   = 12'd3932;
    localparam logic [18:0] RECIP_5     = 19'd419431;   // ceil(2^21 / 5)
    localparam logic [18:0] RECIP_50    = 19'd335545;   // ceil(2^24 / 50)

    // configuration registers
    logic               enable_reg;
    logic signed [19:0] angle_min_reg;
    logic [16:0]        angle_step_reg;
    logic [9:0]         front_first_reg;
    logic [9:0]         front_last_reg;
    logic [15:0]        stop_dist_reg;
    logic [15:0]        min_valid_reg;
    logic [7:0]         pause_ticks_reg;

    logic       cfg_write;
    logic [2:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg      <= 1'b0;
            angle_min_reg   <= -20'sd205887;
            angle_step_reg  <= 17'd402;
            front_first_reg <= 10'd469;
            front_last_reg  <= 10'd555;
            stop_dist_reg   <= 16'd1500;
            min_valid_reg   <= 16'd500;
            pause_ticks_reg <= 8'd30;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_ENABLE:      enable_reg      <= pwdata[0];
                REG_ANGLE_MIN:   angle_min_reg   <= signed'(pwdata[19:0]);
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata[16:0];
                REG_FRONT_FIRST: front_first_reg <= pwdata[9:0];
                REG_FRONT_LAST:  front_last_reg  <= pwdata[9:0];
                REG_STOP_DIST:   stop_dist_reg   <= pwdata[15:0];
                REG_MIN_VALID:   min_valid_reg   <= pwdata[15:0];
                REG_PAUSE:       pause_ticks_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_ENABLE:      prdata = {31'd0, enable_reg};
            REG_ANGLE_MIN:   prdata = 32'(angle_min_reg);
            REG_ANGLE_STEP:  prdata = {15'd0, angle_step_reg};
            REG_FRONT_FIRST: prdata = {22'd0, front_first_reg};
            REG_FRONT_LAST:  prdata = {22'd0, front_last_reg};
            REG_STOP_DIST:   prdata = {16'd0, stop_dist_reg};
            REG_MIN_VALID:   prdata = {16'd0, min_valid_reg};
            REG_PAUSE:       prdata = {24'd0, pause_ticks_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // input register and result register handshake
    logic        in_valid_reg, in_valid_next;
    logic        in_kind_reg;
    logic [15:0] in_range_reg;
    logic        in_finite_reg;
    logic        in_last_reg;
    logic        m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg;
    logic        out_free, advance, s_accept;
    logic        sample_en, tick_en;

    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign sample_en = advance && !in_kind_reg;
    assign tick_en   = advance && in_kind_reg && enable_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (tick_en) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg   <= s_tuser;
            in_range_reg  <= s_tdata[15:0];
            in_finite_reg <= s_tdata[16];
            in_last_reg   <= s_tlast;
        end
    end

    // scan summary
    lwn_scan_cfg_t      scan_cfg;
    lwn_scan_sum_t      held;
    logic [IDX_W-1:0]   held_best_index;

    always_comb begin
        scan_cfg.min_valid_range = min_valid_reg;
        if (front_first_reg > front_last_reg) begin
            scan_cfg.win_lo = front_last_reg;
            scan_cfg.win_hi = front_first_reg;
        end else begin
            scan_cfg.win_lo = front_first_reg;
            scan_cfg.win_hi = front_last_reg;
        end
    end

    lwn_scan #(
        .SCAN_POINTS (SCAN_POINTS),
        .IDX_W       (IDX_W)
    ) u_scan (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .sample_en       (sample_en),
        .range_mm        (in_range_reg),
        .range_finite    (in_finite_reg),
        .scan_end        (in_last_reg),
        .cfg             (scan_cfg),
        .held            (held),
        .held_best_index (held_best_index)
    );

    // navigation state
    logic [1:0]         mode_reg, mode_next;
    logic signed [31:0] rem_reg, rem_next;
    logic [7:0]         pause_cnt_reg, pause_cnt_next;

    logic [IDX_W+16:0]  angle_prod;
    logic [31:0]        target_angle;
    logic [31:0]        mag;
    logic [17:0]        x4;
    logic [17:0]        x4_round;
    logic [36:0]        tm_prod;
    logic [36:0]        dm_prod;
    logic [15:0]        tm;
    logic [11:0]        dm;
    logic [7:0]         pause_inc;
    logic               waiting;
    logic [15:0]        lin;
    logic signed [16:0] turn;

    always_comb begin
        angle_prod   = (IDX_W+17)'(held_best_index) * (IDX_W+17)'(angle_step_reg);
        target_angle = 32'(angle_min_reg) + 32'(angle_prod);

        mag      = rem_reg[31] ? 32'(-rem_reg) : 32'(rem_reg);
        x4       = {mag[15:0], 2'b10};
        x4_round = x4 + 18'd25;
        tm_prod  = 37'(x4) * 37'(RECIP_5);
        dm_prod  = 37'(x4_round) * 37'(RECIP_50);
        if (mag > CLAMP_MAG) begin
            tm = TURN_LIMIT;
            dm = TURN_STEP;
        end else begin
            tm = tm_prod[36:21];
            dm = dm_prod[35:24];
        end

        pause_inc = pause_cnt_reg + 8'd1;

        mode_next      = mode_reg;
        rem_next       = rem_reg;
        pause_cnt_next = pause_cnt_reg;
        waiting        = 1'b0;
        lin            = 16'd0;
        turn           = 17'sd0;

        if (cfg_write && cfg_index == REG_ENABLE) begin
            mode_next      = MODE_SEARCH;
            rem_next       = 32'sd0;
            pause_cnt_next = 8'd0;
        end else if (!held.scan_ready || angle_step_reg == 17'd0) begin
            waiting = 1'b1;
        end else begin
            case (mode_reg)
                MODE_SEARCH: begin
                    if (held.best_found) begin
                        rem_next  = signed'(target_angle);
                        mode_next = MODE_ALIGN;
                    end
                end
                MODE_ALIGN: begin
                    if (mag <= ALIGN_TOL) begin
                        mode_next = MODE_MOVE;
                    end else if (rem_reg[31]) begin
                        turn     = -signed'(17'(tm));
                        rem_next = rem_reg + signed'(32'(dm));
                    end else begin
                        turn     = signed'(17'(tm));
                        rem_next = rem_reg - signed'(32'(dm));
                    end
                end
                MODE_MOVE: begin
                    if (held.front_found && held.front_min <= stop_dist_reg) begin
                        pause_cnt_next = 8'd0;
                        mode_next      = MODE_STOP;
                    end else begin
                        lin = FWD_SPEED;
                    end
                end
                default: begin
                    pause_cnt_next = pause_inc;
                    if (pause_inc >= pause_ticks_reg) begin
                        pause_cnt_next = 8'd0;
                        mode_next      = MODE_SEARCH;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_SEARCH;
            rem_reg       <= 32'sd0;
            pause_cnt_reg <= 8'd0;
        end else if (tick_en || (cfg_write && cfg_index == REG_ENABLE)) begin
            mode_reg      <= mode_next;
            rem_reg       <= rem_next;
            pause_cnt_reg <= pause_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            m_data_reg <= {4'd0, waiting, mode_next, turn, lin};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> tb/lidar_wander_navigator_core_test.sv
`default_nettype none

module lidar_wander_navigator_core_test;
    import lwn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_POINTS    = SCAN_POINTS_DEF;
    localparam int FWD_SPEED      = 260;
    localparam int TURN_LIMIT     = 39322;
    localparam int ALIGN_TOL      = 6554;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef enum logic [1:0] {
        NAV_SEARCH = 2'd0,
        NAV_ALIGN  = 2'd1,
        NAV_MOVE   = 2'd2,
        NAV_STOP   = 2'd3
    } nav_mode_e;

    typedef enum logic [2:0] {
        REG_ENABLE      = 3'd0,
        REG_ANGLE_MIN   = 3'd1,
        REG_ANGLE_STEP  = 3'd2,
        REG_FRONT_FIRST = 3'd3,
        REG_FRONT_LAST  = 3'd4,
        REG_STOP_DIST   = 3'd5,
        REG_MIN_RANGE   = 3'd6,
        REG_PAUSE_TICKS = 3'd7
    } nav_reg_e;

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_TICK   = 1'b1
    } item_kind_e;

    typedef struct packed {
        logic [15:0]        speed;
        logic signed [16:0] rate;
        nav_mode_e          state;
        logic               waiting;
    } nav_cmd_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // configuration copy
    logic               cfg_enable      = 1'b0;
    logic signed [19:0] cfg_angle_min   = -20'sd205887;
    logic [16:0]        cfg_angle_step  = 17'd402;
    logic [9:0]         cfg_front_first = 10'd469;
    logic [9:0]         cfg_front_last  = 10'd555;
    logic [15:0]        cfg_stop_dist   = 16'd1500;
    logic [15:0]        cfg_min_range   = 16'd500;
    logic [7:0]         cfg_pause       = 8'd30;

    // navigation and scan tracking state
    nav_mode_e   nav_mode        = NAV_SEARCH;
    int          nav_remaining   = 0;
    logic [7:0]  nav_pause_cnt   = '0;
    logic [10:0] scan_idx        = '0;
    logic [15:0] run_best_range  = '0;
    logic [9:0]  run_best_idx    = '0;
    logic        run_best_ok     = 1'b0;
    logic [15:0] run_front_min   = 16'hFFFF;
    logic        run_front_ok    = 1'b0;
    logic [9:0]  held_best_idx   = '0;
    logic        held_best_ok    = 1'b0;
    logic [15:0] held_front_min  = 16'hFFFF;
    logic        held_front_ok   = 1'b0;
    logic        scan_ready      = 1'b0;

    nav_cmd_t    expected_cmds[$];
    int          mismatches      = 0;
    int          quiet_cycles    = 0;
    int          recv_stall_left = 0;
    int          send_gap_pct    = 20;
    int          recv_stall_pct  = 20;
    bit          calm            = 1'b0;

    lidar_wander_navigator_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic bit steer_for_item(input item_kind_e kind, input logic [15:0] r,
                                          input logic fin, input logic last,
                                          output nav_cmd_t cmd);
        logic [9:0] lo;
        logic [9:0] hi;
        logic       valid;
        longint     a;
        longint     mag;
        longint     tm;
        longint     dm;
        longint     turn;
        logic [15:0] speed;
        logic        waiting;
        turn    = 0;
        speed   = '0;
        waiting = 1'b0;
        cmd     = '0;
        if (kind == KIND_SAMPLE) begin
            lo = cfg_front_first;
            hi = cfg_front_last;
            if (lo > hi) begin
                lo = cfg_front_last;
                hi = cfg_front_first;
            end
            if (scan_idx < SCAN_POINTS) begin
                valid = fin && (r > cfg_min_range);
                if (valid && r > run_best_range) begin
                    run_best_range = r;
                    run_best_idx   = scan_idx[9:0];
                    run_best_ok    = 1'b1;
                end
                if (valid && scan_idx >= lo && scan_idx <= hi &&
                    (!run_front_ok || r < run_front_min)) begin
                    run_front_min = r;
                    run_front_ok  = 1'b1;
                end
                scan_idx = scan_idx + 11'd1;
            end
            if (last) begin
                held_best_idx  = run_best_idx;
                held_best_ok   = run_best_ok;
                held_front_min = run_front_min;
                held_front_ok  = run_front_ok;
                scan_ready     = 1'b1;
                scan_idx       = '0;
                run_best_range = '0;
                run_best_idx   = '0;
                run_best_ok    = 1'b0;
                run_front_min  = 16'hFFFF;
                run_front_ok   = 1'b0;
            end
            return 1'b0;
        end
        if (!cfg_enable)
            return 1'b0;
        if (!scan_ready || cfg_angle_step == 0) begin
            waiting = 1'b1;
        end else begin
            case (nav_mode)
                NAV_SEARCH: begin
                    if (held_best_ok) begin
                        a = longint'(cfg_angle_min) +
                            longint'(held_best_idx) * longint'(cfg_angle_step);
                        nav_remaining = int'(a);
                        nav_mode      = NAV_ALIGN;
                    end
                end
                NAV_ALIGN: begin
                    a   = nav_remaining;
                    mag = (a < 0) ? -a : a;
                    if (mag <= ALIGN_TOL) begin
                        nav_mode = NAV_MOVE;
                    end else begin
                        tm = (mag * 4 + 2) / 5;
                        if (tm > TURN_LIMIT)
                            tm = TURN_LIMIT;
                        turn = (a < 0) ? -tm : tm;
                        dm   = (tm + 5) / 10;
                        nav_remaining = int'((a < 0) ? a + dm : a - dm);
                    end
                end
                NAV_MOVE: begin
                    if (held_front_ok && held_front_min <= cfg_stop_dist) begin
                        nav_pause_cnt = '0;
                        nav_mode      = NAV_STOP;
                    end else begin
                        speed = 16'(FWD_SPEED);
                    end
                end
                default: begin
                    nav_pause_cnt = nav_pause_cnt + 8'd1;
                    if (nav_pause_cnt >= cfg_pause) begin
                        nav_pause_cnt = '0;
                        nav_mode      = NAV_SEARCH;
                    end
                end
            endcase
        end
        cmd.speed   = speed;
        cmd.rate    = turn[16:0];
        cmd.state   = nav_mode;
        cmd.waiting = waiting;
        return 1'b1;
    endfunction

    task automatic send_item(input item_kind_e kind, input logic [15:0] r, input logic fin,
                             input logic last);
        int       gap;
        nav_cmd_t cmd;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < send_gap_pct)
            gap = $urandom_range(1, 11);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {7'd0, fin, r};
        do @(posedge aclk); while (!s_tready);
        if (steer_for_item(kind, r, fin, last, cmd))
            expected_cmds.push_back(cmd);
    endtask

    task automatic send_tick();
        send_item(KIND_TICK, 16'($urandom), 1'($urandom), 1'($urandom));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_reg(input nav_reg_e idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_ENABLE: begin
                cfg_enable    = val[0];
                nav_mode      = NAV_SEARCH;
                nav_remaining = 0;
                nav_pause_cnt = '0;
            end
            REG_ANGLE_MIN:   cfg_angle_min   = val[19:0];
            REG_ANGLE_STEP:  cfg_angle_step  = val[16:0];
            REG_FRONT_FIRST: cfg_front_first = val[9:0];
            REG_FRONT_LAST:  cfg_front_last  = val[9:0];
            REG_STOP_DIST:   cfg_stop_dist   = val[15:0];
            REG_MIN_RANGE:   cfg_min_range   = val[15:0];
            default:         cfg_pause       = val[7:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result receiver with random stall bursts
    always @(posedge aclk) begin
        if (recv_stall_left != 0) begin
            recv_stall_left <= recv_stall_left - 1;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < recv_stall_pct) begin
            recv_stall_left <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        nav_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cmds.size() == 0) begin
                $display("%0t ns: unexpected result transaction, expected none, actual %h",
                         $time, m_tdata);
                mismatches++;
            end else begin
                want = expected_cmds.pop_front();
                check_field("linear_speed", longint'(want.speed), longint'(m_tdata[15:0]));
                check_field("angular_rate", longint'(want.rate),
                            longint'($signed(m_tdata[32:16])));
                check_field("nav_state", longint'(want.state), longint'(m_tdata[34:33]));
                check_field("waiting_for_scan", longint'(want.waiting),
                            longint'(m_tdata[35]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("lidar_wander_navigator_core_test NOT OK");
                $finish;
            end
        end
    end

    task automatic test_reset_defaults();
        send_tick();
        send_item(KIND_SAMPLE, 16'd3000, 1'b1, 1'b0);
        send_tick();
        drain_results();
        write_reg(REG_ENABLE, 32'd1);
        send_tick();
        send_tick();
        drain_results();
    endtask

    task automatic test_default_long_scan();
        int i;
        for (i = 0; i < SCAN_POINTS + 6; i++) begin
            if (i >= SCAN_POINTS)
                send_item(KIND_SAMPLE, 16'hFFFF, 1'b1, i == SCAN_POINTS + 5);
            else
                send_item(KIND_SAMPLE, 16'($urandom_range(0, 12000)),
                          $urandom_range(0, 15) != 0, 1'b0);
        end
        repeat (30) send_tick();
        drain_results();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_ANGLE_MIN, -411775);
        write_reg(REG_ANGLE_STEP, 32'd65536);
        write_reg(REG_FRONT_FIRST, 32'd0);
        write_reg(REG_FRONT_LAST, 32'd1023);
        write_reg(REG_STOP_DIST, 32'd65535);
        write_reg(REG_MIN_RANGE, 32'd0);
        write_reg(REG_PAUSE_TICKS, 32'd255);
        write_reg(REG_ENABLE, 32'd1);
        send_item(KIND_SAMPLE, 16'd1, 1'b1, 1'b0);
        send_item(KIND_SAMPLE, 16'd2, 1'b1, 1'b1);
        send_tick();
        send_tick();
        drain_results();
        // zero step holds the command at stop
        write_reg(REG_ANGLE_STEP, 32'd0);
        send_tick();
        drain_results();
        // no valid sample in the scan
        write_reg(REG_ANGLE_MIN, 32'd411775);
        write_reg(REG_MIN_RANGE, 32'd65535);
        write_reg(REG_STOP_DIST, 32'd0);
        write_reg(REG_ANGLE_STEP, 32'd1);
        write_reg(REG_PAUSE_TICKS, 32'd1);
        write_reg(REG_ENABLE, 32'd1);
        send_item(KIND_SAMPLE, 16'hFFFF, 1'b1, 1'b1);
        send_tick();
        drain_results();
        write_reg(REG_ENABLE, 32'd0);
        send_tick();
        drain_results();
    endtask

    task automatic test_nav_directed();
        // reversed window, infinite reading, tie on the longest range, zero pause
        write_reg(REG_ANGLE_MIN, 32'd0);
        write_reg(REG_ANGLE_STEP, 32'd1000);
        write_reg(REG_FRONT_FIRST, 32'd3);
        write_reg(REG_FRONT_LAST, 32'd1);
        write_reg(REG_STOP_DIST, 32'd1500);
        write_reg(REG_MIN_RANGE, 32'd500);
        write_reg(REG_PAUSE_TICKS, 32'd0);
        write_reg(REG_ENABLE, 32'd1);
        send_item(KIND_SAMPLE, 16'hFFFF, 1'b0, 1'b0);
        send_item(KIND_SAMPLE, 16'd400, 1'b1, 1'b0);
        send_item(KIND_SAMPLE, 16'd9000, 1'b1, 1'b0);
        send_item(KIND_SAMPLE, 16'd1200, 1'b1, 1'b0);
        send_item(KIND_SAMPLE, 16'd9000, 1'b1, 1'b1);
        repeat (5) send_tick();
        drain_results();
        // proportional turn toward a moderate angle
        write_reg(REG_ANGLE_MIN, 32'd10000);
        write_reg(REG_ENABLE, 32'd1);
        repeat (6) send_tick();
        drain_results();
        // front window past the end of the scan
        write_reg(REG_FRONT_FIRST, 32'd900);
        write_reg(REG_FRONT_LAST, 32'd1000);
        write_reg(REG_ANGLE_MIN, 32'd0);
        write_reg(REG_ENABLE, 32'd1);
        send_item(KIND_SAMPLE, 16'd3000, 1'b1, 1'b0);
        send_item(KIND_SAMPLE, 16'd3100, 1'b1, 1'b1);
        repeat (3) send_tick();
        drain_results();
    endtask

    task automatic test_random_phases();
        int          phase;
        int          n;
        int          scan_len;
        int          pos;
        int          amin;
        logic [15:0] r;
        logic        last;
        for (phase = 0; phase < 5; phase++) begin
            drain_results();
            calm = (phase == 4);
            case ($urandom_range(0, 2))
                0: send_gap_pct = 0;
                1: send_gap_pct = 15;
                default: send_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: recv_stall_pct = 0;
                1: recv_stall_pct = 15;
                default: recv_stall_pct = 40;
            endcase
            if ($urandom_range(0, 3) == 0)
                amin = int'($urandom_range(0, 823550)) - 411775;
            else
                amin = int'($urandom_range(0, 60000)) - 30000;
            write_reg(REG_ANGLE_MIN, amin);
            case ($urandom_range(0, 7))
                0: write_reg(REG_ANGLE_STEP, 32'd0);
                1: write_reg(REG_ANGLE_STEP, 32'd65536);
                default: write_reg(REG_ANGLE_STEP, $urandom_range(0, 3000));
            endcase
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_FRONT_FIRST, $urandom_range(0, 1023));
                write_reg(REG_FRONT_LAST, $urandom_range(0, 1023));
            end else begin
                write_reg(REG_FRONT_FIRST, $urandom_range(0, 25));
                write_reg(REG_FRONT_LAST, $urandom_range(0, 25));
            end
            write_reg(REG_STOP_DIST, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                                   : $urandom_range(0, 4000));
            write_reg(REG_MIN_RANGE, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                                   : $urandom_range(0, 1500));
            write_reg(REG_PAUSE_TICKS, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                                     : $urandom_range(0, 6));
            write_reg(REG_ENABLE, $urandom_range(0, 5) != 0);
            scan_len = $urandom_range(1, 6);
            pos = 0;
            for (n = 0; n < 12; n++) begin
                if ($urandom_range(0, 99) < 45) begin
                    case ($urandom_range(0, 3))
                        0: r = 16'($urandom);
                        1: r = cfg_min_range + 16'($urandom_range(0, 4)) - 16'd2;
                        2: r = cfg_stop_dist + 16'($urandom_range(0, 4)) - 16'd2;
                        default: r = 16'($urandom_range(0, 12000));
                    endcase
                    last = (pos + 1 >= scan_len) || ($urandom_range(0, 49) == 0);
                    send_item(KIND_SAMPLE, r, $urandom_range(0, 9) != 0, last);
                    pos++;
                    if (last) begin
                        pos = 0;
                        scan_len = $urandom_range(1, 6);
                    end
                end else begin
                    send_tick();
                end
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_default_long_scan();
        test_register_extremes();
        test_nav_directed();
        test_random_phases();
        drain_results();
        if (mismatches == 0) begin
            $display("lidar_wander_navigator_core_test OK");
        end else begin
            $display("lidar_wander_navigator_core_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
